@@ hdl/slmm_pkg.sv @@
package slmm_pkg;

	localparam int ADDR_W = 48;
	localparam int IN_DATA_W = 152;
	localparam int OUT_DATA_W = 88;
	localparam int CFG_ADDR_W = 5;

	localparam logic [2:0] REG_RSSI_LO = 3'd0;
	localparam logic [2:0] REG_RSSI_HI = 3'd1;
	localparam logic [2:0] REG_RATE_LO = 3'd2;
	localparam logic [2:0] REG_RATE_HI = 3'd3;
	localparam logic [2:0] REG_RETRY_LIM = 3'd4;

	localparam logic [1:0] CLS_NORMAL = 2'd0;
	localparam logic [1:0] CLS_LOW = 2'd1;
	localparam logic [1:0] CLS_HIGH = 2'd2;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [2:0] {
		EV_NEW = 3'd0,
		EV_SIGNAL = 3'd1,
		EV_RATE = 3'd2,
		EV_RETRY = 3'd3,
		EV_REMOVED = 3'd4
	} event_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE,
		ST_CALC,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic search;
		logic remove;
		logic insert;
		logic calc;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic search_done;
		logic op_rem;
		logic found;
		logic free;
		logic div_done;
		logic pend_any;
		logic pend_one;
		logic out_free;
	} stat_t;

	typedef struct packed {
		logic [7:0] rssi_lo;
		logic [7:0] rssi_hi;
		logic [31:0] rate_lo;
		logic [31:0] rate_hi;
		logic [31:0] retry_lim;
	} limits_t;

	typedef struct packed {
		logic [7:0] avg_sig;
		logic [31:0] avg_rate;
		logic [1:0] sig_cls;
		logic [1:0] rate_cls;
		logic [31:0] prev_ret;
		logic [31:0] prev_byt;
	} metric_t;

	function automatic logic [1:0] classify(input logic [31:0] v, input logic [31:0] lo,
			input logic [31:0] hi);
		logic [1:0] c;
		if (v < lo)
			c = CLS_LOW;
		else if (v > hi)
			c = CLS_HIGH;
		else
			c = CLS_NORMAL;
		return c;
	endfunction

endpackage

@@ hdl/slmm_ram.sv @@
module slmm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

@@ hdl/slmm_ctrl.sv @@
module slmm_ctrl import slmm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input stat_t stat,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_done)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				cmd.search = 1'b1;
				if (stat.search_done)
					state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (stat.op_rem) begin
					if (stat.found) begin
						cmd.remove = 1'b1;
						state_d = ST_EMIT;
					end else begin
						state_d = ST_IDLE;
					end
				end else if (!stat.found && !stat.free) begin
					state_d = ST_IDLE;
				end else begin
					cmd.insert = !stat.found;
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_done)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!stat.pend_any) begin
					state_d = ST_IDLE;
				end else if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.pend_one)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

@@ hdl/slmm_dp.sv @@
module slmm_dp import slmm_pkg::*; #(
	parameter int STATIONS = 32
) (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	output stat_t stat,
	input limits_t limits,
	input logic [IN_DATA_W-1:0] s_tdata,
	input logic s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [2:0] m_tuser,
	output logic m_tlast
);
	localparam int IW = (STATIONS > 1) ? $clog2(STATIONS) : 1;
	localparam logic [IW:0] NSLOT = (IW+1)'(STATIONS);
	localparam logic [IW-1:0] LAST_IDX = IW'(STATIONS - 1);
	localparam int MW = $bits(metric_t);

	// report register
	logic op_q, sig_ok_q;
	logic [ADDR_W-1:0] addr_q;
	logic [7:0] sig_q;
	logic [31:0] rate_q, ret_q, byt_q;
	logic [32:0] rate_prod;

	assign rate_prod = {7'd0, s_tdata[82:57]} * 33'd100;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= s_tuser;
			addr_q <= s_tdata[47:0];
			sig_ok_q <= s_tdata[48];
			sig_q <= s_tdata[56:49];
			rate_q <= rate_prod[32] ? 32'hFFFF_FFFF : rate_prod[31:0];
			ret_q <= s_tdata[114:83];
			byt_q <= s_tdata[146:115];
		end
	end

	// table search
	logic [IW:0] iss_q;
	logic rvld_s1, found_q, free_q, new_q, issue;
	logic [IW-1:0] idx_s1, fidx_q, fridx_q, clr_q, slot;
	logic [ADDR_W:0] a_rdata, a_wdata;
	logic a_we;
	logic [IW-1:0] a_waddr;

	assign issue = cmd.search && (iss_q != NSLOT);
	assign slot = found_q ? fidx_q : fridx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q <= '0;
			rvld_s1 <= 1'b0;
			found_q <= 1'b0;
			free_q <= 1'b0;
			clr_q <= '0;
			new_q <= 1'b0;
		end else begin
			if (cmd.clear)
				clr_q <= clr_q + 1'b1;
			if (cmd.load) begin
				iss_q <= '0;
				rvld_s1 <= 1'b0;
				found_q <= 1'b0;
				free_q <= 1'b0;
				new_q <= 1'b0;
			end else begin
				rvld_s1 <= issue;
				if (issue)
					iss_q <= iss_q + 1'b1;
				if (rvld_s1) begin
					if (a_rdata[ADDR_W]) begin
						if (!found_q && a_rdata[ADDR_W-1:0] == addr_q)
							found_q <= 1'b1;
					end else if (!free_q) begin
						free_q <= 1'b1;
					end
				end
				if (cmd.insert)
					new_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= iss_q[IW-1:0];
		if (rvld_s1) begin
			if (a_rdata[ADDR_W] && !found_q && a_rdata[ADDR_W-1:0] == addr_q)
				fidx_q <= idx_s1;
			if (!a_rdata[ADDR_W] && !free_q)
				fridx_q <= idx_s1;
		end
	end

	assign a_we = cmd.clear || cmd.insert || cmd.remove;
	assign a_waddr = cmd.clear ? clr_q : slot;
	assign a_wdata = {cmd.insert, addr_q};

	slmm_ram #(.WIDTH(ADDR_W + 1), .DEPTH(STATIONS)) u_addr_ram (
		.clk(clk),
		.we(a_we),
		.waddr(a_waddr),
		.wdata(a_wdata),
		.raddr(iss_q[IW-1:0]),
		.rdata(a_rdata)
	);

	// metric update
	logic [MW-1:0] m_rdata;
	metric_t old_m, new_m;
	logic [8:0] sig_sum;
	logic [32:0] rate_sum;
	logic [1:0] sig_c, rate_c;
	logic ev_sig, ev_rate, chk;
	logic [31:0] d_ret, d_byt;

	assign old_m = new_q ? metric_t'('0) : metric_t'(m_rdata);

	always_comb begin
		new_m = old_m;
		sig_sum = {1'b0, old_m.avg_sig} + {1'b0, sig_q};
		rate_sum = {1'b0, old_m.avg_rate} + {1'b0, rate_q};
		if (sig_ok_q)
			new_m.avg_sig = (old_m.avg_sig != 8'd0) ? sig_sum[8:1] : sig_q;
		if (rate_q != 32'd0)
			new_m.avg_rate = (old_m.avg_rate != 32'd0) ? rate_sum[32:1] : rate_q;
		sig_c = classify({24'd0, new_m.avg_sig}, {24'd0, limits.rssi_lo},
			{24'd0, limits.rssi_hi});
		rate_c = classify(new_m.avg_rate, limits.rate_lo, limits.rate_hi);
		ev_sig = (new_m.avg_sig != 8'd0) && (sig_c != old_m.sig_cls);
		ev_rate = (new_m.avg_rate != 32'd0) && (rate_c != old_m.rate_cls);
		if (ev_sig)
			new_m.sig_cls = sig_c;
		if (ev_rate)
			new_m.rate_cls = rate_c;
		new_m.prev_ret = ret_q;
		new_m.prev_byt = byt_q;
		chk = old_m.prev_ret != 32'd0;
		d_ret = ret_q - old_m.prev_ret;
		d_byt = byt_q - old_m.prev_byt;
	end

	slmm_ram #(.WIDTH(MW), .DEPTH(STATIONS)) u_metric_ram (
		.clk(clk),
		.we(cmd.calc),
		.waddr(slot),
		.wdata(new_m),
		.raddr(slot),
		.rdata(m_rdata)
	);

	logic [7:0] avg_sig_q;
	logic [31:0] avg_rate_q;
	logic [1:0] sig_cls_q, rate_cls_q;

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			avg_sig_q <= new_m.avg_sig;
			avg_rate_q <= new_m.avg_rate;
			sig_cls_q <= new_m.sig_cls;
			rate_cls_q <= new_m.rate_cls;
		end
	end

	// restoring divider, one quotient bit per cycle
	logic div_busy_q;
	logic [5:0] div_cnt_q;
	logic [31:0] quo_q, rem_q, dvs_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q <= '0;
		end else if (cmd.calc) begin
			div_busy_q <= chk && (d_ret != 32'd0);
			div_cnt_q <= '0;
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q + 1'b1;
			if (div_cnt_q == 6'd31)
				div_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			quo_q <= d_byt;
			rem_q <= '0;
			dvs_q <= d_ret;
		end else if (div_busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	// pending events, bit position is the event code
	logic [4:0] pend_q, eff, rest;
	event_t ev_sel;

	assign eff = {pend_q[4], pend_q[3] && (quo_q > limits.retry_lim), pend_q[2:0]};

	always_comb begin
		priority if (eff[0])
			ev_sel = EV_NEW;
		else if (eff[1])
			ev_sel = EV_SIGNAL;
		else if (eff[2])
			ev_sel = EV_RATE;
		else if (eff[3])
			ev_sel = EV_RETRY;
		else
			ev_sel = EV_REMOVED;
		rest = eff;
		rest[ev_sel] = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (cmd.load) begin
			pend_q <= '0;
		end else begin
			if (cmd.insert)
				pend_q[EV_NEW] <= 1'b1;
			if (cmd.remove)
				pend_q[EV_REMOVED] <= 1'b1;
			if (cmd.calc) begin
				pend_q[EV_SIGNAL] <= ev_sig;
				pend_q[EV_RATE] <= ev_rate;
				pend_q[EV_RETRY] <= chk && (d_ret != 32'd0);
			end
			if (cmd.emit)
				pend_q <= rest;
		end
	end

	// output register
	logic m_tvalid_q, m_tlast_q;
	logic [2:0] m_tuser_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [1:0] lvl;
	logic [31:0] val;

	always_comb begin
		unique case (ev_sel)
			EV_SIGNAL: begin
				lvl = sig_cls_q;
				val = {24'd0, avg_sig_q};
			end
			EV_RATE: begin
				lvl = rate_cls_q;
				val = avg_rate_q;
			end
			EV_RETRY: begin
				lvl = CLS_NORMAL;
				val = quo_q;
			end
			default: begin
				lvl = CLS_NORMAL;
				val = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (cmd.emit)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_tuser_q <= ev_sel;
			m_tdata_q <= {6'd0, val, lvl, addr_q};
			m_tlast_q <= (rest == 5'd0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;
	assign m_tlast = m_tlast_q;

	assign stat.clear_done = (clr_q == LAST_IDX);
	assign stat.search_done = rvld_s1 && (idx_s1 == LAST_IDX);
	assign stat.op_rem = (op_q == OP_REMOVE);
	assign stat.found = found_q;
	assign stat.free = free_q;
	assign stat.div_done = !div_busy_q;
	assign stat.pend_any = (eff != 5'd0);
	assign stat.pend_one = $onehot(eff);
	assign stat.out_free = !m_tvalid_q || m_tready;

	a_emit_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (eff != 5'd0))
		else $error("emit with no pending event");
	a_addr_write_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, cmd.insert, cmd.remove}))
		else $error("conflicting address table writes");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid_q || m_tready))
		else $error("result overwritten before transaction");
	a_emit_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy_q |-> !cmd.emit)
		else $error("emit while divider busy");
endmodule

@@ hdl/station_link_metric_monitor.sv @@
// Station link metric monitor. Keeps a table of STATIONS stations keyed by
// 48-bit address, averages signal and rate per station and reports new,
// removed, class change and retry events on the result stream. After reset
// every table slot is cleared before the first report is taken. A report is
// accepted, then the table is searched (one slot read per cycle from the
// address memory), the station is looked up and updated or removed, the
// bit-serial divider runs when the retry check needs it, and the results
// are given, at most three; a result that waits on m_tready stalls the report.
module station_link_metric_monitor import slmm_pkg::*; #(
	parameter int STATIONS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// station_addr[47:0], signal_valid[48], signal[56:49], bitrate[82:57],
	// retry_count[114:83], byte_count[146:115]
	input logic [IN_DATA_W-1:0] s_tdata,
	// op
	input logic s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// addr_out[47:0], level[49:48], value[81:50]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// event_res
	output logic [2:0] m_tuser,
	output logic m_tlast,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [CFG_ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	limits_t limits_q;
	cmd_t cmd;
	stat_t stat;
	logic cfg_we;
	logic [2:0] reg_idx;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.rssi_lo <= 8'd0;
			limits_q.rssi_hi <= 8'hFF;
			limits_q.rate_lo <= 32'd0;
			limits_q.rate_hi <= 32'hFFFF_FFFF;
			limits_q.retry_lim <= 32'hFFFF_FFFF;
		end else if (cfg_we) begin
			unique case (reg_idx)
				REG_RSSI_LO: limits_q.rssi_lo <= pwdata[7:0];
				REG_RSSI_HI: limits_q.rssi_hi <= pwdata[7:0];
				REG_RATE_LO: limits_q.rate_lo <= pwdata;
				REG_RATE_HI: limits_q.rate_hi <= pwdata;
				REG_RETRY_LIM: limits_q.retry_lim <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RSSI_LO: prdata = {24'd0, limits_q.rssi_lo};
			REG_RSSI_HI: prdata = {24'd0, limits_q.rssi_hi};
			REG_RATE_LO: prdata = limits_q.rate_lo;
			REG_RATE_HI: prdata = limits_q.rate_hi;
			REG_RETRY_LIM: prdata = limits_q.retry_lim;
			default: prdata = '0;
		endcase
	end

	slmm_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat(stat),
		.cmd(cmd)
	);

	slmm_dp #(.STATIONS(STATIONS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.limits(limits_q),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);
endmodule
